/* rtl/core/jhs_pkg.sv */
// Shared constants, register indexes and types for the Jacobi heat stencil sweep.
// No dependencies; the top level takes everything here by scoped name.
package jhs_pkg;

    // Grid limits and field widths
    localparam int MAX_GRID  = 1024;
    localparam int MIN_GRID  = 4;
    localparam int BUF_DEPTH = MAX_GRID + 2;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int IDX_W     = 11;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = VAL_W + 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int M_DATA_W  = ((VAL_W + 2 * IDX_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VALUE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCES_ENABLE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [IDX_W-1:0] GRID_SIZE_RST    = 11'd256;
    localparam logic [VAL_W-1:0] SOURCE_VALUE_RST = 16'd25600;

    typedef logic [VAL_W-1:0] value_t;
    typedef logic [IDX_W-1:0] index_t;

    // One line-buffer entry: the two previous rows of one column
    typedef struct packed {
        value_t older;
        value_t newer;
    } column_t;

endpackage

/* rtl/core/jacobi_heat_stencil_sweep_top.sv */
// Top level of the Jacobi heat stencil sweep: counters, line-buffer memory,
// stencil datapath and output register. Depends on jhs_pkg.
//
// The block takes one padded grid cell per clock cycle in raster order and
// gives the updated interior cell through the stage-1 and output registers
// after the cell below-right of it; border cells give no result. Throughput
// is one cell per cycle, held only by back-pressure on the result side. The
// two previous rows live in one 1026 x 32-bit memory (one read and one write
// port, registered read); each column is read once per row and written back
// two cells later, so the memory port pair sets the rate. The memory needs no
// clearing pass: each entry a sweep uses is written earlier in the same sweep.
module jacobi_heat_stencil_sweep_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_wr_en,
    input  logic [jhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jhs_pkg::CFG_W-1:0]  cfg_wdata,
    // input cell stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [jhs_pkg::VAL_W-1:0]  s_tdata,   // [15:0] cell_value
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [jhs_pkg::M_DATA_W-1:0] m_tdata, // [15:0] new_value, [26:16] row_index,
                                                  // [37:27] col_index, [39:38] zero
    output logic                       m_tlast    // last_cell
);

    localparam int IDX_BAND_W = jhs_pkg::IDX_W + 1;

    // Configuration registers
    jhs_pkg::index_t grid_size_reg;
    jhs_pkg::value_t source_value_reg;
    logic            sources_enable_reg;

    // Raster counters
    jhs_pkg::index_t row_cnt_reg, row_cnt_next;
    jhs_pkg::index_t col_cnt_reg, col_cnt_next;

    // Stage 1: cell waiting for its memory read data
    logic            s1_valid_reg;
    jhs_pkg::index_t s1_row_reg;
    jhs_pkg::index_t s1_col_reg;
    jhs_pkg::value_t s1_cell_reg;

    // Line-buffer memory
    jhs_pkg::column_t line_mem [jhs_pkg::BUF_DEPTH];
    jhs_pkg::column_t mem_rdata_reg;

    // History of the two previous cells and their memory entries
    logic            hv1_reg, hv2_reg;
    jhs_pkg::column_t hist1_reg;
    jhs_pkg::value_t hist2_newer_reg;
    jhs_pkg::value_t cell1_reg, cell2_reg;
    jhs_pkg::index_t addr1_reg, addr2_reg;

    // Output register
    logic            m_valid_reg, m_valid_next;
    jhs_pkg::value_t out_value_reg;
    jhs_pkg::index_t out_row_reg;
    jhs_pkg::index_t out_col_reg;
    logic            out_last_reg;

    // Control and datapath wires
    logic            s_accept;
    logic            s1_adv;
    logic            s1_result;
    logic            wr_en;
    jhs_pkg::index_t n_eff;
    jhs_pkg::index_t n_plus1;
    jhs_pkg::index_t orow, ocol;
    logic [jhs_pkg::SUM_W-1:0] sum4;
    jhs_pkg::value_t avg;
    jhs_pkg::value_t res_value;
    logic [8:0]      band_q;
    logic [8:0]      band_h;
    logic [12:0]     n_x3;
    logic [IDX_BAND_W-1:0] band_a, band_b;

    // Check whether a padded coordinate lies in one of the two source bands
    function automatic logic in_band(input jhs_pkg::index_t pos,
                                     input logic [IDX_BAND_W-1:0] lo_a,
                                     input logic [IDX_BAND_W-1:0] lo_b,
                                     input logic [8:0] width);
        logic [IDX_BAND_W-1:0] p;
        logic [IDX_BAND_W-1:0] w;
        p = {1'b0, pos};
        w = IDX_BAND_W'(width);
        return ((p >= lo_a) && (p < lo_a + w)) || ((p >= lo_b) && (p < lo_b + w));
    endfunction

    // Saturate grid size and derive source band bounds
    always_comb begin
        if (grid_size_reg < jhs_pkg::index_t'(jhs_pkg::MIN_GRID)) begin
            n_eff = jhs_pkg::index_t'(jhs_pkg::MIN_GRID);
        end else if (grid_size_reg > jhs_pkg::index_t'(jhs_pkg::MAX_GRID)) begin
            n_eff = jhs_pkg::index_t'(jhs_pkg::MAX_GRID);
        end else begin
            n_eff = grid_size_reg;
        end
        n_plus1 = n_eff + 1'b1;
        band_q  = n_eff[10:2];
        band_h  = {1'b0, band_q[8:1]};
        n_x3    = {2'b00, n_eff} + {1'b0, n_eff, 1'b0};
        band_a  = IDX_BAND_W'(band_q) - IDX_BAND_W'(band_h);
        band_b  = IDX_BAND_W'(n_x3[12:2]) - IDX_BAND_W'(band_h);
    end

    // Handshake: accept while stage 1 is empty or moving on
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;
    assign wr_en    = s1_adv && hv2_reg;

    // Advance raster counters, wrapping rows and sweeps
    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (s_accept) begin
            if (col_cnt_reg >= n_plus1) begin
                col_cnt_next = '0;
                row_cnt_next = (row_cnt_reg >= n_plus1) ? '0 : row_cnt_reg + 1'b1;
            end else begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    // Stencil: up from older row, left and right from newer row, down from last cell
    always_comb begin
        s1_result = (s1_row_reg >= 11'd2) && (s1_col_reg >= 11'd2)
                 && (s1_row_reg <= n_plus1) && (s1_col_reg <= n_plus1);
        orow      = s1_row_reg - 1'b1;
        ocol      = s1_col_reg - 1'b1;
        sum4      = jhs_pkg::SUM_W'(hist1_reg.older) + jhs_pkg::SUM_W'(cell1_reg)
                  + jhs_pkg::SUM_W'(hist2_newer_reg) + jhs_pkg::SUM_W'(mem_rdata_reg.newer);
        avg       = sum4[jhs_pkg::SUM_W-1:2];
        if (sources_enable_reg && in_band(orow, band_a, band_b, band_q)
            && in_band(ocol, band_a, band_b, band_q)) begin
            res_value = source_value_reg;
        end else begin
            res_value = avg;
        end
    end

    assign m_valid_next = (s1_adv && s1_result) || (m_valid_reg && !m_tready);

    // Hold configuration, counters and valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg      <= jhs_pkg::GRID_SIZE_RST;
            source_value_reg   <= jhs_pkg::SOURCE_VALUE_RST;
            sources_enable_reg <= 1'b1;
            row_cnt_reg        <= '0;
            col_cnt_reg        <= '0;
            s1_valid_reg       <= 1'b0;
            hv1_reg            <= 1'b0;
            hv2_reg            <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    jhs_pkg::REG_GRID_SIZE:      grid_size_reg <= cfg_wdata[jhs_pkg::IDX_W-1:0];
                    jhs_pkg::REG_SOURCE_VALUE:   source_value_reg <= cfg_wdata[jhs_pkg::VAL_W-1:0];
                    jhs_pkg::REG_SOURCES_ENABLE: sources_enable_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                hv1_reg <= 1'b1;
                hv2_reg <= hv1_reg;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the transferred cell and its raster position
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_row_reg  <= row_cnt_reg;
            s1_col_reg  <= col_cnt_reg;
            s1_cell_reg <= s_tdata;
        end
    end

    // Line-buffer memory: read the incoming column, write back the one two cells back
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem_rdata_reg <= line_mem[col_cnt_reg[jhs_pkg::ADDR_W-1:0]];
        end
        if (wr_en) begin
            line_mem[addr2_reg[jhs_pkg::ADDR_W-1:0]] <= '{older: hist2_newer_reg,
                                                          newer: cell2_reg};
        end
    end

    // Shift the cell and column history as stage 1 moves on
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            hist1_reg       <= mem_rdata_reg;
            hist2_newer_reg <= hist1_reg.newer;
            cell1_reg       <= s1_cell_reg;
            cell2_reg       <= cell1_reg;
            addr1_reg       <= s1_col_reg;
            addr2_reg       <= addr1_reg;
        end
    end

    // Load the output register with each result
    always_ff @(posedge aclk) begin
        if (s1_adv && s1_result) begin
            out_value_reg <= res_value;
            out_row_reg   <= orow;
            out_col_reg   <= ocol;
            out_last_reg  <= (orow == n_eff) && (ocol == n_eff);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(jhs_pkg::M_DATA_W - jhs_pkg::VAL_W - 2 * jhs_pkg::IDX_W){1'b0}},
                       out_col_reg, out_row_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

    // Write-back never hits the column being read in the same cycle
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && s_accept) |-> (addr2_reg != col_cnt_reg))
        else $error("line buffer read and write hit the same column");

    // Input stalls only while a result is blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without output back-pressure");

    // The last cell sits on the diagonal
    a_last_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_last_reg) |-> (out_row_reg == out_col_reg))
        else $error("last cell off the grid diagonal");

    // Column counter stays inside the line buffer
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_cnt_reg <= jhs_pkg::index_t'(jhs_pkg::MAX_GRID + 1))
        else $error("column counter beyond line buffer");

    // A blocked result stays until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg)
        else $error("result dropped while blocked");

endmodule
